[sv/tone_melody_sequencer_unit_macros.svh]
// Assertion macros shared by the tone melody sequencer modules.
`ifndef TONE_MELODY_SEQUENCER_UNIT_MACROS_SVH
`define TONE_MELODY_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define TMS_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// next-cycle implication
`define TMS_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

[sv/tms_pkg.sv]
// Types and constants of the tone melody sequencer.
`default_nettype none
package tms_pkg;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_PLAY    = 2'd1;
	localparam logic [1:0] OP_STOP    = 2'd2;
	localparam logic [1:0] OP_NOTE_WR = 2'd3;

	localparam logic [15:0] PERIOD_STOPPED = 16'hFFFF;
	localparam logic [7:0]  PULSE_RESET    = 8'd10;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  note_address;
		logic [15:0] note_period;
		logic [15:0] note_duration;
		logic [7:0]  song_start;
		logic [8:0]  song_length;
	} item_t;

	typedef struct packed {
		logic       play;
		logic [7:0] start;
		logic [8:0] len;
	} cmd_t;

	typedef struct packed {
		logic [15:0] duration;
		logic [15:0] period;
	} note_t;

	typedef struct packed {
		logic  en;
		logic [7:0] index;
		note_t data;
	} note_wr_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] period;
		logic [7:0]  compare;
		logic        active;
		logic [8:0]  position;
	} result_t;

endpackage
`default_nettype wire

[sv/tone_melody_sequencer_unit.sv]
// Top level of the tone melody sequencer: handshakes, config register, datapath.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+-------------------------------
//  item     | in        | item_valid / item_stall    | opcode, note and song fields
//  result   | out       | result_valid / result_stall| accepted, tone state, position
//  cfg      | in        | cfg_valid / cfg_ready      | cfg_data (tone pulse width)
//
// One word per cycle unless the result is stalled; each item is held in the input
// register item_s1, then its result sits in the output register res_s2.
// Note and command memories are read ahead, addressed from the next state.
// Reset clears pointers, player state and valids; the pulse width resets to 10.
// A stalled result holds the input register, which then stalls the item side.
`default_nettype none
module tone_melody_sequencer_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int NOTE_DEPTH  = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  note_address,
	input  wire logic [15:0] note_period,
	input  wire logic [15:0] note_duration,
	input  wire logic [7:0]  song_start,
	input  wire logic [8:0]  song_length,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             accepted,
	output logic [15:0]      tone_period,
	output logic [7:0]       tone_compare,
	output logic             tone_enable,
	output logic             playing,
	output logic [8:0]       note_position,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	localparam int NAW = $clog2(NOTE_DEPTH);

	tms_pkg::item_t    item_s1;
	logic              vld_s1;
	tms_pkg::result_t  res_s2;
	logic              vld_s2;
	logic [7:0]        pulse_q;
	logic              go;
	tms_pkg::result_t  result;
	tms_pkg::q_ctl_t   q_ctl;
	tms_pkg::q_stat_t  q_stat;
	tms_pkg::cmd_t     push_cmd;
	tms_pkg::cmd_t     front;
	tms_pkg::cmd_t     front_nx;
	tms_pkg::note_wr_t note_wr;
	tms_pkg::note_t    next_note;
	tms_pkg::note_t    first_note;
	logic [NAW-1:0]    next_addr;
	logic [NAW-1:0]    first_addr;

	assign go         = vld_s1 && (!vld_s2 || !result_stall);
	assign item_stall = vld_s1 && !go;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			pulse_q <= tms_pkg::PULSE_RESET;
		end else begin
			if (!item_stall) begin
				vld_s1 <= item_valid;
			end
			if (go) begin
				vld_s2 <= 1'b1;
			end else if (!result_stall) begin
				vld_s2 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				pulse_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1.opcode        <= opcode;
			item_s1.note_address  <= note_address;
			item_s1.note_period   <= note_period;
			item_s1.note_duration <= note_duration;
			item_s1.song_start    <= song_start;
			item_s1.song_length   <= song_length;
		end
		if (go) begin
			res_s2 <= result;
		end
	end

	tms_cmd_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (q_ctl),
		.push_cmd (push_cmd),
		.stat     (q_stat),
		.front    (front),
		.front_nx (front_nx)
	);

	tms_note_mem #(
		.NOTE_DEPTH(NOTE_DEPTH)
	) u_notes (
		.clk     (clk),
		.wr      (note_wr),
		.a_addr  (next_addr),
		.b_start (front_nx.start),
		.a_data  (next_note),
		.b_data  (first_note),
		.b_addr  (first_addr)
	);

	tms_player #(
		.NOTE_DEPTH(NOTE_DEPTH)
	) u_player (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.item        (item_s1),
		.pulse_width (pulse_q),
		.q_stat      (q_stat),
		.front       (front),
		.next_note   (next_note),
		.first_note  (first_note),
		.first_addr  (first_addr),
		.q_ctl       (q_ctl),
		.push_cmd    (push_cmd),
		.note_wr     (note_wr),
		.next_addr   (next_addr),
		.result      (result)
	);

	assign result_valid  = vld_s2;
	assign accepted      = res_s2.accepted;
	assign tone_period   = res_s2.period;
	assign tone_compare  = res_s2.compare;
	assign tone_enable   = res_s2.active;
	assign playing       = res_s2.active;
	assign note_position = res_s2.position;

endmodule
`default_nettype wire

[sv/tms_cmd_queue.sv]
// Command ring buffer with two registered read ports at the tail.
`default_nettype none
`include "tone_melody_sequencer_unit_macros.svh"
module tms_cmd_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tms_pkg::q_ctl_t ctl,
	input  wire tms_pkg::cmd_t   push_cmd,
	output tms_pkg::q_stat_t     stat,
	output tms_pkg::cmd_t        front,
	output tms_pkg::cmd_t        front_nx
);

	localparam int QW = $clog2(QUEUE_DEPTH);

	function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] p);
		return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	tms_pkg::cmd_t cmd_mem [QUEUE_DEPTH];
	tms_pkg::cmd_t rd0_q;
	tms_pkg::cmd_t rd1_q;
	logic [QW-1:0] head_q;
	logic [QW-1:0] tail_q;
	logic [QW-1:0] head_nx;
	logic [QW-1:0] tail_d;
	logic [QW-1:0] tail_d1;
	logic          do_push;

	assign head_nx    = wrap_inc(head_q);
	assign stat.full  = (head_nx == tail_q);
	assign stat.empty = (head_q == tail_q);
	assign do_push    = ctl.push && !stat.full;
	assign tail_d     = ctl.pop ? wrap_inc(tail_q) : tail_q;
	assign tail_d1    = wrap_inc(tail_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (do_push) begin
				head_q <= head_nx;
			end
			tail_q <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			cmd_mem[head_q] <= push_cmd;
		end
		rd0_q <= (do_push && head_q == tail_d) ? push_cmd : cmd_mem[tail_d];
		rd1_q <= (do_push && head_q == tail_d1) ? push_cmd : cmd_mem[tail_d1];
	end

	assign front    = rd0_q;
	assign front_nx = (do_push && head_q == tail_d) ? push_cmd : (ctl.pop ? rd1_q : rd0_q);

	`TMS_ASSERT_NOW(a_pop_nonempty, ctl.pop, !stat.empty, "pop from empty command queue")
	`TMS_ASSERT_NEXT(a_full_hold, ctl.push && stat.full, $stable(head_q), "head moved on full queue")

endmodule
`default_nettype wire

[sv/tms_note_mem.sv]
// Note memory with one write port and two registered read ports.
`default_nettype none
module tms_note_mem #(
	parameter int NOTE_DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire tms_pkg::note_wr_t             wr,
	input  wire logic [$clog2(NOTE_DEPTH)-1:0] a_addr,
	input  wire logic [7:0]                    b_start,
	output tms_pkg::note_t                     a_data,
	output tms_pkg::note_t                     b_data,
	output logic [$clog2(NOTE_DEPTH)-1:0]      b_addr
);

	localparam int NAW = $clog2(NOTE_DEPTH);

	typedef logic [NAW-1:0] mod_tbl_t [256];

	function automatic mod_tbl_t build_mod_tbl();
		mod_tbl_t t;
		logic [NAW-1:0] r;
		r = '0;
		for (int i = 0; i < 256; i++) begin
			t[i] = r;
			r = (r == NAW'(NOTE_DEPTH - 1)) ? '0 : r + 1'b1;
		end
		return t;
	endfunction

	localparam mod_tbl_t MOD_TBL = build_mod_tbl();

	tms_pkg::note_t note_mem [NOTE_DEPTH];
	tms_pkg::note_t a_data_q;
	tms_pkg::note_t b_data_q;
	logic [NAW-1:0] b_addr_q;
	logic [NAW-1:0] wr_addr;
	logic [NAW-1:0] b_addr_d;

	assign wr_addr  = MOD_TBL[wr.index];
	assign b_addr_d = MOD_TBL[b_start];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			note_mem[wr_addr] <= wr.data;
		end
		a_data_q <= (wr.en && wr_addr == a_addr) ? wr.data : note_mem[a_addr];
		b_data_q <= (wr.en && wr_addr == b_addr_d) ? wr.data : note_mem[b_addr_d];
		b_addr_q <= b_addr_d;
	end

	assign a_data = a_data_q;
	assign b_data = b_data_q;
	assign b_addr = b_addr_q;

endmodule
`default_nettype wire

[sv/tms_player.sv]
// Melody player state: note timing, command execution and result values.
`default_nettype none
`include "tone_melody_sequencer_unit_macros.svh"
module tms_player #(
	parameter int NOTE_DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire tms_pkg::item_t                item,
	input  wire logic [7:0]                    pulse_width,
	input  wire tms_pkg::q_stat_t              q_stat,
	input  wire tms_pkg::cmd_t                 front,
	input  wire tms_pkg::note_t                next_note,
	input  wire tms_pkg::note_t                first_note,
	input  wire logic [$clog2(NOTE_DEPTH)-1:0] first_addr,
	output tms_pkg::q_ctl_t                    q_ctl,
	output tms_pkg::cmd_t                      push_cmd,
	output tms_pkg::note_wr_t                  note_wr,
	output logic [$clog2(NOTE_DEPTH)-1:0]      next_addr,
	output tms_pkg::result_t                   result
);

	localparam int NAW = $clog2(NOTE_DEPTH);

	function automatic logic [NAW-1:0] wrap_inc(input logic [NAW-1:0] p);
		return (p == NAW'(NOTE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic           active_q, active_d;
	logic [15:0]    per_q, per_d;
	logic [7:0]     cmp_q, cmp_d;
	logic [8:0]     pos_q, pos_d;
	logic [8:0]     len_q, len_d;
	logic [15:0]    el_q, el_d;
	logic [15:0]    dur_q, dur_d;
	logic [NAW-1:0] addr_q, addr_d;
	logic           acc;

	assign push_cmd.play  = (item.opcode == tms_pkg::OP_PLAY);
	assign push_cmd.start = item.song_start;
	assign push_cmd.len   = item.song_length;

	assign note_wr.en            = go && (item.opcode == tms_pkg::OP_NOTE_WR);
	assign note_wr.index         = item.note_address;
	assign note_wr.data.duration = item.note_duration;
	assign note_wr.data.period   = item.note_period;

	always_comb begin
		active_d = active_q;
		per_d    = per_q;
		cmp_d    = cmp_q;
		pos_d    = pos_q;
		len_d    = len_q;
		el_d     = el_q;
		dur_d    = dur_q;
		addr_d   = addr_q;
		acc      = 1'b1;
		q_ctl    = '0;
		if (go) begin
			unique case (item.opcode) inside
				tms_pkg::OP_TICK: begin
					if (active_q) begin
						el_d = el_q + 16'd1;
						if (el_d >= dur_q) begin
							pos_d = pos_q + 9'd1;
							if (pos_d >= len_q) begin
								active_d = 1'b0;
								per_d    = tms_pkg::PERIOD_STOPPED;
								cmp_d    = 8'd0;
							end else begin
								addr_d = wrap_inc(addr_q);
								el_d   = '0;
								dur_d  = next_note.duration;
								if (next_note.period == 16'd0) begin
									cmp_d = 8'd0;
								end else begin
									per_d = next_note.period;
									cmp_d = pulse_width;
								end
							end
						end
					end
					if (!q_stat.empty) begin
						q_ctl.pop = 1'b1;
						if (front.play && front.len != 9'd0) begin
							len_d    = front.len;
							pos_d    = '0;
							active_d = 1'b1;
							addr_d   = first_addr;
							el_d     = '0;
							dur_d    = first_note.duration;
							if (first_note.period == 16'd0) begin
								cmp_d = 8'd0;
							end else begin
								per_d = first_note.period;
								cmp_d = pulse_width;
							end
						end else begin
							active_d = 1'b0;
							per_d    = tms_pkg::PERIOD_STOPPED;
							cmp_d    = 8'd0;
						end
					end
				end
				tms_pkg::OP_PLAY, tms_pkg::OP_STOP: begin
					q_ctl.push = 1'b1;
					acc        = !q_stat.full;
				end
				tms_pkg::OP_NOTE_WR: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			per_q    <= tms_pkg::PERIOD_STOPPED;
			cmp_q    <= '0;
			pos_q    <= '0;
			len_q    <= '0;
			el_q     <= '0;
			dur_q    <= '0;
			addr_q   <= '0;
		end else begin
			active_q <= active_d;
			per_q    <= per_d;
			cmp_q    <= cmp_d;
			pos_q    <= pos_d;
			len_q    <= len_d;
			el_q     <= el_d;
			dur_q    <= dur_d;
			addr_q   <= addr_d;
		end
	end

	assign next_addr = wrap_inc(addr_d);

	assign result.accepted = acc;
	assign result.period   = per_d;
	assign result.compare  = cmp_d;
	assign result.active   = active_d;
	assign result.position = pos_d;

	`TMS_ASSERT_NOW(a_idle_silent, !active_q, (per_q == tms_pkg::PERIOD_STOPPED) && (cmp_q == 8'd0), "tone left on while idle")
	`TMS_ASSERT_NOW(a_pos_in_range, active_q, pos_q < len_q, "note position past melody end")

endmodule
`default_nettype wire
